[design/sofc_pkg.sv]
package sofc_pkg;

   // Fixed field widths.
   localparam int unsigned TIME_W     = 64;
   localparam int unsigned LIMIT_W    = 31;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned OFFSET_W   = 64;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Default number of fraction bits of the running average.
   localparam int unsigned AVG_FRACTION_BITS_DEF = 16;

   // Register values after reset.
   localparam logic               SYNC_MODE_RESET = 1'b1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 31'd1000;
   localparam logic [COUNT_W-1:0] AVG_COUNT_RESET = 8'd10;
   localparam logic [COUNT_W-1:0] RETRY_RESET     = 8'd5;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FIRST,
      PH_PRELIM,
      PH_AVERAGE
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEXT,
      ST_DONE,
      ST_ABORT,
      ST_IDLE
   } status_type;

   typedef enum logic [1:0] {
      CSR_SYNC_MODE,
      CSR_LIMIT,
      CSR_AVG_COUNT,
      CSR_RETRY
   } csr_reg_type;

   typedef enum logic {
      KIND_START,
      KIND_EXCHANGE
   } kind_type;

   // One exchange word after the offset has been formed and range checked.
   typedef struct packed {
      logic                       kind;
      logic                       ok;
      logic                       in_limit;
      logic signed [OFFSET_W-1:0] offset;
   } item_type;

   // Result of the sequencer before the average is rounded to microseconds.
   typedef struct packed {
      logic                       corr_valid;
      logic                       use_avg;
      status_type                 status;
      logic signed [OFFSET_W-1:0] value;
   } res_type;

endpackage

[design/sofc_req_if.sv]
interface sofc_req_if;
   import sofc_pkg::*;

   logic              valid;
   logic              ready;
   logic              item_kind;
   logic              response_ok;
   logic [TIME_W-1:0] client_send_time;
   logic [TIME_W-1:0] server_receive_time;
   logic [TIME_W-1:0] server_send_time;
   logic [TIME_W-1:0] client_receive_time;

   modport source (
      output valid, item_kind, response_ok, client_send_time, server_receive_time,
             server_send_time, client_receive_time,
      input  ready
   );

   modport sink (
      input  valid, item_kind, response_ok, client_send_time, server_receive_time,
             server_send_time, client_receive_time,
      output ready
   );
endinterface

[design/sofc_rsp_if.sv]
interface sofc_rsp_if;
   import sofc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       correction_valid;
   logic signed [OFFSET_W-1:0] correction_value;
   logic [STATUS_W-1:0]        status;

   modport source (
      output valid, correction_valid, correction_value, status,
      input  ready
   );

   modport sink (
      input  valid, correction_valid, correction_value, status,
      output ready
   );
endinterface

[design/sofc_front.sv]
// Two-stage front end: timestamp differences, then the halved offset and its
// range check against the distortion limit.
module sofc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [sofc_pkg::LIMIT_W-1:0]    limit,
   sofc_req_if.sink                        req_bus,
   output logic                            out_valid,
   input  logic                            out_ready,
   output sofc_pkg::item_type              out_item
);
   import sofc_pkg::*;

   logic              v1_ff, v1_in;
   logic              v2_ff, v2_in;
   logic              open1, open2;
   logic              kind1_ff, kind1_in;
   logic              ok1_ff, ok1_in;
   logic [TIME_W-1:0] fwd_ff, fwd_in;
   logic [TIME_W-1:0] back_ff, back_in;
   item_type          item_ff, item_in;

   logic signed [TIME_W:0] sum;
   logic signed [TIME_W:0] pos_bound;
   logic signed [TIME_W:0] neg_bound;
   logic                   odd_neg;

   assign open2         = ~v2_ff | out_ready;
   assign open1         = ~v1_ff | open2;
   assign req_bus.ready = open1;

   // The exact sum needs one extra bit; halving toward zero rounds a negative
   // odd sum up by one. The limit test works on the sum itself:
   // |sum / 2| <= L holds exactly when -(2L+1) <= sum <= 2L+1.
   assign sum       = {fwd_ff[TIME_W-1], fwd_ff} + {back_ff[TIME_W-1], back_ff};
   assign odd_neg   = sum[TIME_W] & sum[0];
   assign pos_bound = {{(TIME_W - LIMIT_W){1'b0}}, limit, 1'b1};
   assign neg_bound = -pos_bound;

   always_comb begin
      v1_in    = open1 ? req_bus.valid : v1_ff;
      v2_in    = open2 ? v1_ff : v2_ff;
      kind1_in = kind1_ff;
      ok1_in   = ok1_ff;
      fwd_in   = fwd_ff;
      back_in  = back_ff;
      item_in  = item_ff;
      if (open1 && req_bus.valid) begin
         kind1_in = req_bus.item_kind;
         ok1_in   = req_bus.response_ok;
         fwd_in   = req_bus.server_receive_time - req_bus.client_send_time;
         back_in  = req_bus.server_send_time - req_bus.client_receive_time;
      end
      if (open2 && v1_ff) begin
         item_in.kind     = kind1_ff;
         item_in.ok       = ok1_ff;
         item_in.offset   = sum[TIME_W:1] + {{(OFFSET_W-1){1'b0}}, odd_neg};
         item_in.in_limit = (sum <= pos_bound) && (sum >= neg_bound);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      kind1_ff <= kind1_in;
      ok1_ff   <= ok1_in;
      fwd_ff   <= fwd_in;
      back_ff  <= back_in;
      item_ff  <= item_in;
   end

   assign out_valid = v2_ff;
   assign out_item  = item_ff;

endmodule

[design/sntp_offset_filter_controller_unit.sv]
// SNTP clock offset filter. A start word opens a sync; each exchange word
// reports one request attempt with its four microsecond timestamps, and every
// accepted word yields exactly one result word carrying a status and, when
// the local clock must move, a signed correction in microseconds. The offset
// is ((T2-T1)+(T3-T4))/2 truncated toward zero. Single mode applies the first
// good offset; multiple mode applies a first correction, then preliminary
// corrections until one lies within the distortion limit, then folds in-limit
// offsets into an exponential moving average (k = 0.1 in fixed point) and
// applies its truncated value once average_count of them have been seen.
// The block takes one word per clock while its output is not stalled; each
// word passes four register stages: the timestamp differences, the offset
// with its limit check, the sequencer with the average update (one constant
// multiply), and the output rounding. A stalled result holds the pipeline
// behind it. Configuration is over an APB port at byte addresses 0, 4, 8 and
// 12 and should be written only while no word is in flight.
module sntp_offset_filter_controller_unit #(
   parameter int unsigned AVG_FRACTION_BITS = sofc_pkg::AVG_FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   sofc_req_if.sink                          req_bus,
   sofc_rsp_if.source                        rsp_bus,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sofc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [sofc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [sofc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import sofc_pkg::*;

   // The average holds a 32-bit microsecond value with the fraction below it.
   localparam int unsigned AVG_W   = 32 + AVG_FRACTION_BITS;
   localparam int unsigned DIFF_W  = AVG_W + 1;
   localparam int unsigned PROD_W  = AVG_W + AVG_FRACTION_BITS;
   localparam longint unsigned ONE = 64'd1 << AVG_FRACTION_BITS;
   localparam longint unsigned K_VAL = (ONE + 64'd5) / 64'd10;
   localparam logic signed [PROD_W-1:0]   K_COEF    = PROD_W'(K_VAL);
   localparam logic signed [OFFSET_W-1:0] ROUND_ADD = OFFSET_W'(ONE - 64'd1);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic               mode_ff, mode_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] avg_count_ff, avg_count_in;
   logic [COUNT_W-1:0] retry_ff, retry_in;
   csr_reg_type        csr_sel;
   logic               csr_wr;

   assign csr_sel = csr_reg_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wr  = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      mode_in      = mode_ff;
      limit_in     = limit_ff;
      avg_count_in = avg_count_ff;
      retry_in     = retry_ff;
      if (csr_wr) begin
         case (csr_sel)
            CSR_SYNC_MODE: mode_in      = pwdata[0];
            CSR_LIMIT:     limit_in     = pwdata[LIMIT_W-1:0];
            CSR_AVG_COUNT: avg_count_in = pwdata[COUNT_W-1:0];
            CSR_RETRY:     retry_in     = pwdata[COUNT_W-1:0];
            default:       mode_in      = mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_SYNC_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         CSR_LIMIT:     prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff};
         CSR_AVG_COUNT: prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, avg_count_ff};
         CSR_RETRY:     prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, retry_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= SYNC_MODE_RESET;
         limit_ff     <= LIMIT_RESET;
         avg_count_ff <= AVG_COUNT_RESET;
         retry_ff     <= RETRY_RESET;
      end else begin
         mode_ff      <= mode_in;
         limit_ff     <= limit_in;
         avg_count_ff <= avg_count_in;
         retry_ff     <= retry_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages one and two: timestamp differences, then offset and limit check.
   // ------------------------------------------------------------------
   logic     s2_valid;
   item_type s2_item;
   logic     open3, open4;
   logic     fire3;

   sofc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .req_bus   (req_bus),
      .out_valid (s2_valid),
      .out_ready (open3),
      .out_item  (s2_item)
   );

   // ------------------------------------------------------------------
   // Stage three: sync sequencer and moving average.
   // ------------------------------------------------------------------
   phase_type                phase_ff, phase_in;
   logic [COUNT_W-1:0]       failed_ff, failed_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic signed [AVG_W-1:0]  avg_ff, avg_in;
   logic                     s3_valid_ff, s3_valid_in;
   res_type                  res_ff, res_in;
   res_type                  res_new;

   logic signed [AVG_W-1:0]  x_scaled;
   logic signed [DIFF_W-1:0] avg_diff;
   logic signed [PROD_W-1:0] avg_prod;
   logic signed [AVG_W-1:0]  avg_step;
   logic signed [AVG_W-1:0]  avg_upd;
   logic [COUNT_W-1:0]       count_inc;
   logic                     retry_spent;
   logic                     avg_done;

   assign open4 = ~rsp_bus.valid | rsp_bus.ready;
   assign open3 = ~s3_valid_ff | open4;
   assign fire3 = s2_valid & open3;

   // Only in-limit offsets reach the average, so the low 32 bits carry the
   // whole value. The update adds floor((x - avg) * k) in fixed point.
   assign x_scaled  = {s2_item.offset[31:0], {AVG_FRACTION_BITS{1'b0}}};
   assign avg_diff  = DIFF_W'(x_scaled) - DIFF_W'(avg_ff);
   assign avg_prod  = PROD_W'(avg_diff) * K_COEF;
   assign avg_step  = AVG_W'(avg_prod >>> AVG_FRACTION_BITS);
   assign avg_upd   = avg_ff + avg_step;

   assign count_inc   = count_ff + 1'b1;
   assign retry_spent = failed_ff >= retry_ff;
   assign avg_done    = count_inc >= avg_count_ff;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (fire3) begin
         if (s2_item.kind == KIND_START) begin
            phase_in = PH_FIRST;
         end else if (phase_ff == PH_IDLE) begin
            phase_in = PH_IDLE;
         end else if (!s2_item.ok) begin
            // A failed request restarts in the first phase and aborts later.
            if (retry_spent && phase_ff != PH_FIRST) begin
               phase_in = PH_IDLE;
            end
         end else begin
            case (phase_ff)
               PH_FIRST: begin
                  phase_in = mode_ff ? PH_PRELIM : PH_IDLE;
               end
               PH_PRELIM: begin
                  if (s2_item.in_limit) begin
                     phase_in = (avg_count_ff == '0) ? PH_IDLE : PH_AVERAGE;
                  end
               end
               PH_AVERAGE: begin
                  if (s2_item.in_limit && avg_done) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // Counters, average and the result of the word.
   always_comb begin
      failed_in          = failed_ff;
      count_in           = count_ff;
      avg_in             = avg_ff;
      res_new.corr_valid = 1'b0;
      res_new.use_avg    = 1'b0;
      res_new.status     = ST_NEXT;
      res_new.value      = '0;
      if (fire3) begin
         if (s2_item.kind == KIND_START) begin
            failed_in = '0;
            count_in  = '0;
            avg_in    = '0;
         end else if (phase_ff == PH_IDLE) begin
            res_new.status = ST_IDLE;
         end else if (!s2_item.ok) begin
            if (retry_spent) begin
               failed_in = '0;
               if (phase_ff != PH_FIRST) begin
                  res_new.status = ST_ABORT;
               end
            end else begin
               failed_in = failed_ff + 1'b1;
            end
         end else begin
            failed_in = '0;
            case (phase_ff)
               PH_FIRST: begin
                  res_new.corr_valid = 1'b1;
                  res_new.value      = s2_item.offset;
                  if (!mode_ff) begin
                     res_new.status = ST_DONE;
                  end
               end
               PH_PRELIM: begin
                  res_new.corr_valid = 1'b1;
                  res_new.value      = s2_item.offset;
                  if (s2_item.in_limit) begin
                     count_in = '0;
                     avg_in   = '0;
                     // An empty average is a zero shift, so the sync ends here.
                     if (avg_count_ff == '0) begin
                        res_new.status = ST_DONE;
                     end
                  end
               end
               PH_AVERAGE: begin
                  // Out-of-limit offsets are skipped without a correction.
                  if (s2_item.in_limit) begin
                     avg_in   = avg_upd;
                     count_in = count_inc;
                     if (avg_done) begin
                        res_new.corr_valid = 1'b1;
                        res_new.use_avg    = 1'b1;
                        res_new.value      = OFFSET_W'(avg_upd);
                        res_new.status     = ST_DONE;
                     end
                  end
               end
               default: res_new.status = ST_NEXT;
            endcase
         end
      end
   end

   always_comb begin
      s3_valid_in = open3 ? s2_valid : s3_valid_ff;
      res_in      = fire3 ? res_new : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         failed_ff   <= '0;
         count_ff    <= '0;
         avg_ff      <= '0;
         s3_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         failed_ff   <= failed_in;
         count_ff    <= count_in;
         avg_ff      <= avg_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   // ------------------------------------------------------------------
   // Stage four: output register. The average is truncated toward zero by
   // biasing negative values before the arithmetic shift.
   // ------------------------------------------------------------------
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       corr_valid_ff, corr_valid_in;
   logic signed [OFFSET_W-1:0] value_ff, value_in;
   status_type                 status_ff, status_in;
   logic signed [OFFSET_W-1:0] round_sum;
   logic signed [OFFSET_W-1:0] avg_out;

   assign round_sum = res_ff.value + (res_ff.value[OFFSET_W-1] ? ROUND_ADD : '0);
   assign avg_out   = round_sum >>> AVG_FRACTION_BITS;

   always_comb begin
      rsp_valid_in  = open4 ? s3_valid_ff : rsp_valid_ff;
      corr_valid_in = corr_valid_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      if (open4 && s3_valid_ff) begin
         corr_valid_in = res_ff.corr_valid;
         value_in      = res_ff.use_avg ? avg_out : res_ff.value;
         status_in     = res_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      corr_valid_ff <= corr_valid_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.correction_valid = corr_valid_ff;
   assign rsp_bus.correction_value = value_ff;
   assign rsp_bus.status           = status_ff;

endmodule

[design/sofc_checker.sv]
// Port-level checks of the offset filter.
module sofc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_correction_valid,
   input logic signed [sofc_pkg::OFFSET_W-1:0] rsp_correction_value,
   input logic [sofc_pkg::STATUS_W-1:0]       rsp_status
);
   import sofc_pkg::*;

   // With the output register empty the whole pipeline can move.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the output register is empty");

   // A word without a correction carries a zero shift.
   a_zero_without_corr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_correction_valid) |-> (rsp_correction_value == '0))
      else $error("nonzero correction value without correction_valid");

   // Aborted and ignored words never move the clock.
   a_no_corr_on_abort: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_ABORT || rsp_status == ST_IDLE))
         |-> !rsp_correction_valid)
      else $error("correction reported with abort or idle status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_correction_value) && $stable(rsp_status)
          && $stable(rsp_correction_valid)))
      else $error("stalled result word changed");

endmodule

bind sntp_offset_filter_controller_unit sofc_checker u_sofc_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_bus.ready),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_correction_valid (rsp_bus.correction_valid),
   .rsp_correction_value (rsp_bus.correction_value),
   .rsp_status           (rsp_bus.status)
);

[tb/sv/sofc_correction_checker.sv]
module sofc_correction_checker (
   input  logic                            clock,
   input  logic                            reset,
   sofc_req_if                             req_mon,
   sofc_rsp_if                             rsp_mon,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [sofc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sofc_pkg::CSR_DATA_W-1:0] pwdata,
   output int unsigned                     mismatch_count,
   output int unsigned                     words_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sofc_pkg::*;

   localparam int     AVG_FRAC = AVG_FRACTION_BITS_DEF;
   localparam longint EMA_GAIN = ((64'sd1 <<< AVG_FRAC) + 5) / 10;

   typedef struct packed {
      logic                       corr_valid;
      logic signed [OFFSET_W-1:0] corr_value;
      status_type                 status;
   } correction_type;

   correction_type pending_corrections[$];
   int unsigned    mismatches;

   // Register copies, updated from the APB writes seen on the port.
   logic               cfg_multi;
   logic [LIMIT_W-1:0] cfg_limit;
   logic [COUNT_W-1:0] cfg_avg_count;
   logic [COUNT_W-1:0] cfg_retry;

   // Sync state of the predictor.
   phase_type                  sync_phase;
   logic [COUNT_W-1:0]         fail_run;
   logic [COUNT_W-1:0]         in_limit_seen;
   logic signed [63:0]         ema_acc;

   function automatic logic signed [63:0] exchange_offset(logic [63:0] t1, logic [63:0] t2,
                                                          logic [63:0] t3, logic [63:0] t4);
      logic [63:0]        fwd;
      logic [63:0]        back;
      logic signed [64:0] total;
      logic signed [64:0] halved;
      fwd    = t2 - t1;
      back   = t3 - t4;
      // The sum is exact in 65 bits; signed division truncates toward zero.
      total  = $signed({fwd[63], fwd}) + $signed({back[63], back});
      halved = total / 65'sd2;
      return halved[63:0];
   endfunction

   function automatic bit offset_fits(logic signed [63:0] off);
      logic signed [63:0] lim;
      lim = $signed({33'd0, cfg_limit});
      return (off <= lim) && (off >= -lim);
   endfunction

   function automatic correction_type predict_correction(logic kind, logic ok,
                                                         logic [63:0] t1, logic [63:0] t2,
                                                         logic [63:0] t3, logic [63:0] t4);
      correction_type     want;
      logic signed [63:0] off;
      logic signed [63:0] diff;
      want.corr_valid = 1'b0;
      want.corr_value = '0;
      want.status     = ST_NEXT;
      if (kind == KIND_START) begin
         sync_phase    = PH_FIRST;
         fail_run      = '0;
         in_limit_seen = '0;
         ema_acc       = '0;
      end else if (sync_phase == PH_IDLE) begin
         want.status = ST_IDLE;
      end else if (!ok) begin
         if (fail_run >= cfg_retry) begin
            fail_run = '0;
            if (sync_phase != PH_FIRST) begin
               sync_phase  = PH_IDLE;
               want.status = ST_ABORT;
            end
         end else begin
            fail_run = fail_run + 1'b1;
         end
      end else begin
         off      = exchange_offset(t1, t2, t3, t4);
         fail_run = '0;
         case (sync_phase)
            PH_FIRST: begin
               want.corr_valid = 1'b1;
               want.corr_value = off;
               if (!cfg_multi) begin
                  sync_phase  = PH_IDLE;
                  want.status = ST_DONE;
               end else begin
                  sync_phase = PH_PRELIM;
               end
            end
            PH_PRELIM: begin
               want.corr_valid = 1'b1;
               want.corr_value = off;
               if (offset_fits(off)) begin
                  in_limit_seen = '0;
                  ema_acc       = '0;
                  if (cfg_avg_count == 0) begin
                     sync_phase  = PH_IDLE;
                     want.status = ST_DONE;
                  end else begin
                     sync_phase = PH_AVERAGE;
                  end
               end
            end
            default: begin
               if (offset_fits(off)) begin
                  // Exact form of avg += floor((x*2^F - avg) * k / 2^F).
                  diff          = (off <<< AVG_FRAC) - ema_acc;
                  ema_acc       = ema_acc + ((diff * EMA_GAIN) >>> AVG_FRAC);
                  in_limit_seen = in_limit_seen + 1'b1;
                  if (in_limit_seen >= cfg_avg_count) begin
                     want.corr_valid = 1'b1;
                     if (ema_acc >= 0)
                        want.corr_value = ema_acc >>> AVG_FRAC;
                     else
                        want.corr_value = -((-ema_acc) >>> AVG_FRAC);
                     sync_phase  = PH_IDLE;
                     want.status = ST_DONE;
                  end
               end
            end
         endcase
      end
      return want;
   endfunction

   task automatic note_mismatch(string what, bit known, correction_type want);
      mismatches++;
      if (mismatches <= 10) begin
         if (known)
            $display({"%0t: %s: expected valid %0b value %0d status %0d, ",
                      "got valid %0b value %0d status %0d"},
                     $time, what, want.corr_valid, want.corr_value, want.status,
                     rsp_mon.correction_valid, rsp_mon.correction_value, rsp_mon.status);
         else
            $display("%0t: %s: got valid %0b value %0d status %0d", $time, what,
                     rsp_mon.correction_valid, rsp_mon.correction_value, rsp_mon.status);
      end
   endtask

   always @(posedge clock) begin
      correction_type want;
      if (reset) begin
         pending_corrections.delete();
         mismatches    = 0;
         cfg_multi     = SYNC_MODE_RESET;
         cfg_limit     = LIMIT_RESET;
         cfg_avg_count = AVG_COUNT_RESET;
         cfg_retry     = RETRY_RESET;
         sync_phase    = PH_IDLE;
         fail_run      = '0;
         in_limit_seen = '0;
         ema_acc       = '0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_reg_type'(paddr[3:2]))
               CSR_SYNC_MODE: cfg_multi     = pwdata[0];
               CSR_LIMIT:     cfg_limit     = pwdata[LIMIT_W-1:0];
               CSR_AVG_COUNT: cfg_avg_count = pwdata[COUNT_W-1:0];
               CSR_RETRY:     cfg_retry     = pwdata[COUNT_W-1:0];
               default:       cfg_multi     = cfg_multi;
            endcase
         end
         // Results are checked before the new word is predicted; a result can
         // never belong to a word accepted on the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_corrections.size() == 0) begin
               want = '0;
               note_mismatch("result word with nothing expected", 1'b0, want);
            end else begin
               want = pending_corrections.pop_front();
               if (rsp_mon.correction_valid !== want.corr_valid)
                  note_mismatch("correction_valid differs", 1'b1, want);
               else if (rsp_mon.correction_value !== want.corr_value)
                  note_mismatch("correction_value differs", 1'b1, want);
               else if (rsp_mon.status !== want.status)
                  note_mismatch("status differs", 1'b1, want);
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_corrections.push_back(predict_correction(
               req_mon.item_kind, req_mon.response_ok, req_mon.client_send_time,
               req_mon.server_receive_time, req_mon.server_send_time,
               req_mon.client_receive_time));
      end
      mismatch_count <= mismatches;
      words_pending  <= pending_corrections.size();
   end

endmodule

[tb/sv/sntp_offset_filter_controller_unit_tb.sv]
module sntp_offset_filter_controller_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sofc_pkg::*;

   // Words per random round; eight rounds make up the bulk of the run.
   localparam int unsigned ROUND_WORDS   = 225;
   // The block has four pipeline stages, so a handful of cycles covers it.
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned DRAIN_LIMIT   = 20000;
   // Long receiver hold-off, far longer than the pipeline is deep.
   localparam int unsigned HOLD_CYCLES   = 300;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   sofc_req_if req_bus ();
   sofc_rsp_if rsp_bus ();

   int unsigned mismatch_count;
   int unsigned words_pending;

   // Idle percentages of the two sides. The stall percentage and the hold
   // ticket are read by the receiver process, so they change only by
   // nonblocking assignment.
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned hold_ticket;
   int unsigned words_sent;

   // Our own copy of the register settings, used to shape the sync sequences.
   logic               cur_multi;
   logic [LIMIT_W-1:0] cur_limit;
   logic [COUNT_W-1:0] cur_avg_count;
   logic [COUNT_W-1:0] cur_retry;

   sntp_offset_filter_controller_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sofc_correction_checker i_chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake must not keep the run alive.
   initial begin
      #10ms;
      $display("sntp_offset_filter_controller_unit_tb: errors");
      $finish;
   end

   // Receiver. Each cycle it stalls with the current percentage. When the
   // hold ticket moves, it drops ready for a long stretch of its own counting
   // so that the pipeline fills and the block pushes back on its input.
   initial begin
      int unsigned hold_served;
      hold_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != hold_served) begin
            hold_served = hold_ticket;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [63:0] rand_time();
      return {$urandom(), $urandom()};
   endfunction

   // Offers one word and returns on the edge at which it is accepted. The
   // valid line is only lowered for idle cycles, never between back to back
   // words, so it sees a single assignment per time step.
   task automatic send_word(kind_type kind, logic ok, logic [63:0] t1, logic [63:0] t2,
                            logic [63:0] t3, logic [63:0] t4);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.item_kind           <= kind;
      req_bus.response_ok         <= ok;
      req_bus.client_send_time    <= t1;
      req_bus.server_receive_time <= t2;
      req_bus.server_send_time    <= t3;
      req_bus.client_receive_time <= t4;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      words_sent++;
   endtask

   // Builds timestamps that give the wanted offset (plus one if negative and
   // odd). The two legs straddle the offset by a small random spread on random
   // base times, and the odd flag makes their sum odd to exercise the truncation.
   task automatic send_offset(logic signed [63:0] off, bit odd);
      logic [63:0]        t1;
      logic [63:0]        t4;
      logic signed [63:0] spread;
      t1     = rand_time();
      t4     = rand_time();
      spread = $signed(64'($urandom_range(20'hFFFFF))) - 64'sd524288;
      send_word(KIND_EXCHANGE, 1'b1, t1, t1 + (off + spread), t4 + (off - spread + odd), t4);
   endtask

   function automatic logic signed [63:0] pick_offset(bit fits);
      logic signed [63:0] lim;
      logic signed [63:0] mag;
      lim = $signed({33'd0, cur_limit});
      if (fits) begin
         case ($urandom_range(3))
            0:       mag = lim;
            1:       mag = (lim > 3) ? lim - 64'($urandom_range(3)) : 64'sd0;
            default: mag = 64'($urandom_range(cur_limit));
         endcase
      end else begin
         case ($urandom_range(2))
            0:       mag = lim + 1 + 64'($urandom_range(7));
            1:       mag = lim + 1 + 64'($urandom());
            default: return $signed(rand_time());
         endcase
      end
      return $urandom_range(1) ? -mag : mag;
   endfunction

   task automatic good_word(bit fits);
      send_offset(pick_offset(fits), fits ? bit'($urandom_range(1)) : 1'b0);
   endtask

   task automatic fail_burst(int unsigned count);
      repeat (count)
         send_word(KIND_EXCHANGE, 1'b0, rand_time(), rand_time(), rand_time(), rand_time());
   endtask

   // A few failed attempts, always fewer than would fail the request.
   task automatic minor_failures();
      if ($urandom_range(2) == 0)
         fail_burst($urandom_range((cur_retry < 3) ? cur_retry : 3));
   endtask

   task automatic start_word();
      send_word(KIND_START, 1'($urandom_range(1)), rand_time(), rand_time(), rand_time(),
                rand_time());
   endtask

   // One well-formed sync with random content, planned from the current settings
   // so that it walks through the first phase and, in multiple mode, the
   // preliminary and averaging phases. Some syncs are broken on purpose: a stray
   // exchange while idle, a restart while busy, a failed first request, or an abort.
   task automatic run_sync();
      bit          abort_avg;
      int unsigned abort_point;
      int unsigned in_avg;
      abort_avg   = ($urandom_range(7) == 0);
      abort_point = (cur_avg_count == 0) ? 0 : $urandom_range(cur_avg_count - 1);
      in_avg      = 0;
      if ($urandom_range(9) == 0)
         send_word(KIND_EXCHANGE, 1'($urandom_range(1)), rand_time(), rand_time(),
                   rand_time(), rand_time());
      start_word();
      if ($urandom_range(9) == 0) begin
         fail_burst($urandom_range(2));
         start_word();
      end
      // A failed request in the first phase simply opens a fresh request.
      if ($urandom_range(4) == 0)
         fail_burst(cur_retry + 1);
      minor_failures();
      good_word(1'($urandom_range(1)));
      if (!cur_multi)
         return;
      repeat ($urandom_range(3)) begin
         minor_failures();
         good_word(1'b0);
      end
      if ($urandom_range(9) == 0) begin
         fail_burst(cur_retry + 1);
         return;
      end
      minor_failures();
      good_word(1'b1);
      if (cur_avg_count == 0)
         return;
      while (in_avg < cur_avg_count) begin
         if (abort_avg && in_avg == abort_point) begin
            fail_burst(cur_retry + 1);
            return;
         end
         minor_failures();
         if ($urandom_range(3) == 0) begin
            good_word(1'b0);
         end else begin
            good_word(1'b1);
            in_avg++;
         end
      end
   endtask

   // Waits until every expected result word has come back, then lets the
   // pipeline settle. The first edge is taken before the pending count is
   // looked at, so a word accepted on the current edge is already counted.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_reg_type index, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_settings(logic multi, logic [LIMIT_W-1:0] limit,
                                 logic [COUNT_W-1:0] avg_count, logic [COUNT_W-1:0] retry);
      write_register(CSR_SYNC_MODE, CSR_DATA_W'(multi));
      write_register(CSR_LIMIT, CSR_DATA_W'(limit));
      write_register(CSR_AVG_COUNT, CSR_DATA_W'(avg_count));
      write_register(CSR_RETRY, CSR_DATA_W'(retry));
      cur_multi     = multi;
      cur_limit     = limit;
      cur_avg_count = avg_count;
      cur_retry     = retry;
   endtask

   initial begin
      int unsigned round;
      int unsigned drain_wait;

      reset                       <= 1'b1;
      psel                        <= 1'b0;
      penable                     <= 1'b0;
      pwrite                      <= 1'b0;
      paddr                       <= '0;
      pwdata                      <= '0;
      req_bus.valid               <= 1'b0;
      req_bus.item_kind           <= 1'b0;
      req_bus.response_ok         <= 1'b0;
      req_bus.client_send_time    <= '0;
      req_bus.server_receive_time <= '0;
      req_bus.server_send_time    <= '0;
      req_bus.client_receive_time <= '0;
      stall_pct                   <= 0;
      hold_ticket                 <= 0;
      idle_pct                    = 0;
      words_sent                  = 0;
      cur_multi                   = SYNC_MODE_RESET;
      cur_limit                   = LIMIT_RESET;
      cur_avg_count               = AVG_COUNT_RESET;
      cur_retry                   = RETRY_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings: multiple mode, limit 1000,
      // average of ten, five retries.
      // Exchange words while idle are ignored.
      send_word(KIND_EXCHANGE, 1'b1, '1, '1, '1, '1);
      send_word(KIND_EXCHANGE, 1'b0, '0, '0, '0, '0);
      send_word(KIND_START, 1'b0, '1, '0, '1, '0);
      send_word(KIND_EXCHANGE, 1'b0, '1, '1, '0, '0);
      // Start while busy restarts the sync.
      send_word(KIND_START, 1'b1, '0, '1, '0, '1);
      // First correction: both legs are -1, offset -1.
      send_word(KIND_EXCHANGE, 1'b1, '0, '1, '1, '0);
      // Preliminary corrections at the extremes of the offset range.
      send_word(KIND_EXCHANGE, 1'b1, '0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, '0);
      send_word(KIND_EXCHANGE, 1'b1, '0, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0);
      // The leg sum needs a 65th bit here: (2^63-1) + 1 halves to 2^62.
      send_word(KIND_EXCHANGE, 1'b1, '0, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, '0);
      // Just outside the limit, so still a preliminary correction.
      send_word(KIND_EXCHANGE, 1'b1, 64'd5, 64'd1006, 64'd2001, 64'd1000);
      fail_burst(2);
      // -2001 halves toward zero to -1000, right on the limit: averaging begins.
      send_word(KIND_EXCHANGE, 1'b1, 64'd2000, 64'd1000, 64'd0, 64'd1001);
      // Out of limit while averaging: skipped.
      send_offset(64'sd1001, 1'b0);
      send_offset(-64'sd1001, 1'b0);
      // Ten in-limit offsets finish with the truncated average.
      send_offset(64'sd1000, 1'b0);
      send_offset(-64'sd1000, 1'b0);
      send_offset(-64'sd3, 1'b1);
      send_offset(64'sd0, 1'b1);
      send_offset(-64'sd999, 1'b0);
      send_offset(-64'sd777, 1'b1);
      send_offset(64'sd1, 1'b0);
      send_offset(-64'sd500, 1'b0);
      send_offset(64'sd250, 1'b1);
      send_offset(-64'sd1000, 1'b1);
      drain_results();

      // Random rounds. Each round writes every register, then runs whole
      // syncs until its share of words has been sent, then drains so that
      // the next write lands on an idle block.
      for (round = 0; round < 8; round++) begin
         case (round % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 71; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 71; end
            default: begin idle_pct = 13; stall_pct <= 13; end
         endcase
         case (round)
            0: apply_settings(1'b1, 31'd1000, 8'd3, 8'd2);
            1: apply_settings(1'b0, 31'd0, 8'd1, 8'd0);
            2: apply_settings(1'b1, 31'h7FFF_FFFF, 8'd255, 8'd255);
            3: apply_settings(1'b1, 31'd0, 8'd0, 8'd1);
            4: apply_settings(1'b1, 31'd50, 8'd1, 8'd0);
            default: apply_settings(1'($urandom_range(3) != 0),
                                    $urandom_range(1) ? 31'($urandom_range(5000))
                                                      : 31'($urandom()),
                                    8'($urandom_range(8, 1)), 8'($urandom_range(4)));
         endcase
         // With the sender running flat out, a long receiver hold-off fills
         // the pipeline and makes the block stall its input.
         if (round == 2)
            hold_ticket <= hold_ticket + 1;
         while (words_sent < 25 + (round + 1) * ROUND_WORDS)
            run_sync();
         drain_results();
      end

      req_bus.valid <= 1'b0;
      drain_wait = 0;
      do begin
         @(posedge clock);
         drain_wait++;
      end while (words_pending != 0 && drain_wait < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("sntp_offset_filter_controller_unit_tb: clean");
      else
         $display("sntp_offset_filter_controller_unit_tb: errors");
      $finish;
   end

endmodule
